/* hw/rtl/dbvm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbvm_pkg
// Shared widths, register indexes, reset values and pipeline control types
// for the dual battery voltage monitor.
// ----------------------------------------------------------------------------
package dbvm_pkg;

   localparam int ADC_W    = 10;
   localparam int GAIN_W   = 16;
   localparam int VOLT_W   = 16;
   localparam int RAW_W    = ADC_W + GAIN_W - 8;
   localparam int LIMIT_W  = 16;
   localparam int EVERY_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int WINDOW_DEFAULT = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_FIRST   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_SECOND  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_FIRST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_EVERY  = 3'd4;

   localparam logic [GAIN_W-1:0]  GAIN_FIRST_RST   = 16'd2286;
   localparam logic [GAIN_W-1:0]  GAIN_SECOND_RST  = 16'd2286;
   localparam logic [LIMIT_W-1:0] LIMIT_FIRST_RST  = 16'd2432;
   localparam logic [LIMIT_W-1:0] LIMIT_SECOND_RST = 16'd3328;
   localparam logic [EVERY_W-1:0] ALARM_EVERY_RST  = 6'd20;

   // stage capture strobes, one per pipeline stage
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } dbvm_adv_type;

endpackage

/* hw/rtl/dbvm_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbvm_lane
// One battery channel: scale the count to a Q8 voltage, saturate, keep the
// moving-average window and running sum, and divide the sum by the window.
// ----------------------------------------------------------------------------
module dbvm_lane #(
   parameter int WINDOW = dbvm_pkg::WINDOW_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dbvm_pkg::dbvm_adv_type           adv,
   input  logic [dbvm_pkg::ADC_W-1:0]       adc,
   input  logic [dbvm_pkg::GAIN_W-1:0]      gain,
   input  logic [dbvm_pkg::LIMIT_W-1:0]     limit,
   output logic                             low,
   output logic [dbvm_pkg::VOLT_W-1:0]      volt,
   output logic [dbvm_pkg::VOLT_W-1:0]      mean
);

   localparam int VW     = dbvm_pkg::VOLT_W;
   localparam int RW     = dbvm_pkg::RAW_W;
   localparam int PW     = dbvm_pkg::ADC_W + dbvm_pkg::GAIN_W;
   localparam int LOG_W  = $clog2(WINDOW);
   localparam int SUM_W  = VW + LOG_W;
   localparam int SHIFT  = SUM_W + LOG_W;
   localparam int MUL_W  = SUM_W + 1;
   localparam int MPROD_W = SUM_W + MUL_W;
   // round-up reciprocal, exact for every sum below 2**SUM_W
   localparam longint unsigned MUL_FULL =
      ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [MUL_W-1:0] MUL = MUL_W'(MUL_FULL);

   logic [PW-1:0]       prod_w;
   logic [RW-1:0]       raw_ff;
   logic [VW-1:0]       sat_w;
   logic [VW-1:0]       win_ff [WINDOW];
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [VW-1:0]       volt2_ff;
   logic                low2_ff;
   logic [MPROD_W-1:0]  mprod_w;
   logic [VW-1:0]       volt3_ff;
   logic [VW-1:0]       mean3_ff;

   // stage 1: scale count by gain
   assign prod_w = PW'(adc) * PW'(gain);

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         raw_ff <= prod_w[PW-1:8];
      end
   end

   // stage 2: saturate, compare, update window and running sum
   assign sat_w  = (raw_ff[RW-1:VW] != '0) ? {VW{1'b1}} : raw_ff[VW-1:0];
   assign sum_in = sum_ff - SUM_W'(win_ff[WINDOW-1]) + SUM_W'(sat_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
      end else if (adv.s2) begin
         sum_ff    <= sum_in;
         win_ff[0] <= sat_w;
         for (int i = 1; i < WINDOW; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         volt2_ff <= sat_w;
         // unsaturated voltage against the limit
         low2_ff  <= (raw_ff <= RW'(limit));
      end
   end

   // stage 3: window mean by reciprocal multiply
   assign mprod_w = MPROD_W'(sum_ff) * MPROD_W'(MUL);

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         volt3_ff <= volt2_ff;
         mean3_ff <= mprod_w[SHIFT +: VW];
      end
   end

   assign low  = low2_ff;
   assign volt = volt3_ff;
   assign mean = mean3_ff;

endmodule

/* hw/rtl/dbvm_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbvm_merge
// Combines the two lane compare flags and runs the low-reading counter that
// produces the periodic alarm pulse.
// ----------------------------------------------------------------------------
module dbvm_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  dbvm_pkg::dbvm_adv_type           adv,
   input  logic                             low_first,
   input  logic                             low_second,
   input  logic [dbvm_pkg::EVERY_W-1:0]     alarm_every,
   output logic                             low_seen,
   output logic                             alarm_pulse
);

   localparam int EW = dbvm_pkg::EVERY_W;

   logic [EW-1:0] count_ff;
   logic [EW-1:0] count_in;
   logic          low_ff;
   logic          pulse_ff;
   logic          low_w;
   logic          pulse_w;
   logic [EW:0]   period_w;
   logic [EW:0]   next_w;

   assign low_w    = low_first | low_second;
   // zero period behaves as the full counter range
   assign period_w = (alarm_every == '0) ? (EW+1)'(1) << EW : (EW+1)'(alarm_every);
   assign next_w   = (EW+1)'(count_ff) + (EW+1)'(1);

   always_comb begin
      count_in = count_ff;
      pulse_w  = 1'b0;
      if (low_w) begin
         if (next_w >= period_w) begin
            count_in = '0;
            pulse_w  = 1'b1;
         end else begin
            count_in = next_w[EW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (adv.s3) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         low_ff   <= low_w;
         pulse_ff <= pulse_w;
      end
   end

   assign low_seen    = low_ff;
   assign alarm_pulse = pulse_ff;

endmodule

/* hw/rtl/dual_battery_voltage_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_battery_voltage_monitor
// Two-lane battery monitor: Q8 voltages, moving-average means and an
// undervoltage flag with a periodic alarm pulse.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  adc_first, adc_second
//   rsp      out        rsp_valid/rsp_ready  volts, means, low_seen, alarm_pulse
//   csr      in         csr_we               csr_index, csr_wdata
//
// Three-stage pipeline (scale multiply, window/sum update, mean multiply);
// one transaction per cycle sustained while rsp_ready is held high.
// The running sum and window update once per accepted transaction.
// Reset clears window, sums, alarm counter and valid flags, and sets the configuration registers to defaults.
// A stalled output holds its stages; earlier empty stages keep filling.
// ----------------------------------------------------------------------------
module dual_battery_voltage_monitor #(
   parameter int WINDOW = dbvm_pkg::WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dbvm_pkg::ADC_W-1:0]          req_adc_first,
   input  logic [dbvm_pkg::ADC_W-1:0]          req_adc_second,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dbvm_pkg::VOLT_W-1:0]         rsp_volt_first,
   output logic [dbvm_pkg::VOLT_W-1:0]         rsp_mean_first,
   output logic [dbvm_pkg::VOLT_W-1:0]         rsp_volt_second,
   output logic [dbvm_pkg::VOLT_W-1:0]         rsp_mean_second,
   output logic                                rsp_low_seen,
   output logic                                rsp_alarm_pulse,
   input  logic                                csr_we,
   input  logic [dbvm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dbvm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [dbvm_pkg::GAIN_W-1:0]  gain_first_ff;
   logic [dbvm_pkg::GAIN_W-1:0]  gain_second_ff;
   logic [dbvm_pkg::LIMIT_W-1:0] limit_first_ff;
   logic [dbvm_pkg::LIMIT_W-1:0] limit_second_ff;
   logic [dbvm_pkg::EVERY_W-1:0] alarm_every_ff;

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   dbvm_pkg::dbvm_adv_type adv;
   logic low_first, low_second;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_first_ff   <= dbvm_pkg::GAIN_FIRST_RST;
         gain_second_ff  <= dbvm_pkg::GAIN_SECOND_RST;
         limit_first_ff  <= dbvm_pkg::LIMIT_FIRST_RST;
         limit_second_ff <= dbvm_pkg::LIMIT_SECOND_RST;
         alarm_every_ff  <= dbvm_pkg::ALARM_EVERY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            dbvm_pkg::CSR_GAIN_FIRST: begin
               gain_first_ff <= csr_wdata[dbvm_pkg::GAIN_W-1:0];
            end
            dbvm_pkg::CSR_GAIN_SECOND: begin
               gain_second_ff <= csr_wdata[dbvm_pkg::GAIN_W-1:0];
            end
            dbvm_pkg::CSR_LIMIT_FIRST: begin
               limit_first_ff <= csr_wdata[dbvm_pkg::LIMIT_W-1:0];
            end
            dbvm_pkg::CSR_LIMIT_SECOND: begin
               limit_second_ff <= csr_wdata[dbvm_pkg::LIMIT_W-1:0];
            end
            dbvm_pkg::CSR_ALARM_EVERY: begin
               alarm_every_ff <= csr_wdata[dbvm_pkg::EVERY_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control
   always_comb begin
      adv.s3    = v2_ff && (!v3_ff || rsp_ready);
      adv.s2    = v1_ff && (!v2_ff || adv.s3);
      req_ready = !v1_ff || adv.s2;
      adv.s1    = req_valid && req_ready;
      v1_in     = adv.s1 ? 1'b1 : (adv.s2 ? 1'b0 : v1_ff);
      v2_in     = adv.s2 ? 1'b1 : (adv.s3 ? 1'b0 : v2_ff);
      v3_in     = adv.s3 ? 1'b1 : (rsp_ready ? 1'b0 : v3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   dbvm_lane #(.WINDOW(WINDOW)) u_lane_first (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .adc   (req_adc_first),
      .gain  (gain_first_ff),
      .limit (limit_first_ff),
      .low   (low_first),
      .volt  (rsp_volt_first),
      .mean  (rsp_mean_first)
   );

   dbvm_lane #(.WINDOW(WINDOW)) u_lane_second (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .adc   (req_adc_second),
      .gain  (gain_second_ff),
      .limit (limit_second_ff),
      .low   (low_second),
      .volt  (rsp_volt_second),
      .mean  (rsp_mean_second)
   );

   dbvm_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .low_first   (low_first),
      .low_second  (low_second),
      .alarm_every (alarm_every_ff),
      .low_seen    (rsp_low_seen),
      .alarm_pulse (rsp_alarm_pulse)
   );

   assign rsp_valid = v3_ff;

`ifndef SYNTHESIS
   // pipeline empties on reset and is ready right after
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

   // an accepted transaction always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted transaction lost");

   // an alarm pulse only comes with a low reading
   a_pulse_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_alarm_pulse) |-> rsp_low_seen)
      else $error("alarm pulse without low reading");
`endif

endmodule
